// ===== rtl/core/ttps_pkg.sv =====
package ttps_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4096;
   localparam int unsigned DEPTH_BITS_DEF    = 7;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned REQ_DEPTH_W = 7;
   localparam int unsigned SCORE_W  = 18;
   localparam int unsigned KIND_W   = 2;

   localparam logic [OPCODE_W-1:0] OP_PROBE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BETA  = 2'd2;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_INDEX,
      S_READ,
      S_EVAL,
      S_WRITE,
      S_CLEAR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic index_step;
      logic mem_write;
      logic sweep;
      logic load_eval;
      logic load_zero;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                index_done;
      logic                sweep_last;
   } status_type;

endpackage

// ===== rtl/core/ttps_ram.sv =====
module ttps_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ttps_ctrl.sv =====
module ttps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ttps_pkg::status_type  status,
   output ttps_pkg::cmd_type     cmd
);

   import ttps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new request's result when it is empty
   // or is being emptied in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_INDEX;
         end
         S_INDEX: begin
            if (status.index_done) begin
               unique case (status.op)
                  OP_PROBE: state_in = S_READ;
                  OP_STORE: state_in = S_WRITE;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_READ:  state_in = S_EVAL;
         S_EVAL: begin
            if (out_free) state_in = S_IDLE;
         end
         S_WRITE: state_in = S_DONE;
         S_CLEAR: begin
            if (status.sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT:  cmd.sweep = 1'b1;
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_INDEX: cmd.index_step = 1'b1;
         S_READ:  cmd = '0;
         S_EVAL:  cmd.load_eval = out_free;
         S_WRITE: cmd.mem_write = 1'b1;
         S_CLEAR: cmd.sweep = 1'b1;
         S_DONE:  cmd.load_zero = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_eval || cmd.load_zero) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/ttps_datapath.sv =====
module ttps_datapath #(
   parameter int unsigned TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned DEPTH_BITS    = ttps_pkg::DEPTH_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ttps_pkg::cmd_type                         cmd,
   output ttps_pkg::status_type                      status,
   input  logic        [ttps_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic        [ttps_pkg::KEY_W-1:0]         req_position_key,
   input  logic        [ttps_pkg::REQ_DEPTH_W-1:0]   req_search_depth,
   input  logic signed [ttps_pkg::SCORE_W-1:0]       req_lower_bound,
   input  logic signed [ttps_pkg::SCORE_W-1:0]       req_upper_bound,
   input  logic signed [ttps_pkg::SCORE_W-1:0]       req_store_score,
   input  logic        [ttps_pkg::KIND_W-1:0]        req_bound_kind,
   output logic                                      rsp_hit,
   output logic signed [ttps_pkg::SCORE_W-1:0]       rsp_result_score
);

   import ttps_pkg::*;

   localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int unsigned DEPTH_LSB = KIND_W;
   localparam int unsigned SCORE_LSB = DEPTH_LSB + DEPTH_BITS;
   localparam int unsigned KEY_LSB   = SCORE_LSB + SCORE_W;
   localparam int unsigned VALID_BIT = KEY_LSB + KEY_W;
   localparam int unsigned ENTRY_W   = VALID_BIT + 1;
   localparam bit          IS_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // Captured request.
   logic        [OPCODE_W-1:0]   op_ff;
   logic        [KEY_W-1:0]      key_ff;
   logic        [DEPTH_BITS-1:0] depth_ff;
   logic signed [SCORE_W-1:0]    alpha_ff, beta_ff, score_ff;
   logic        [KIND_W-1:0]     kind_ff;

   logic [IDX_W-1:0] index;
   logic             index_done;

   logic [IDX_W-1:0] sweep_ff, sweep_in;

   logic [IDX_W-1:0]   ram_addr;
   logic               ram_wr_en;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   logic                     e_valid;
   logic [KEY_W-1:0]         e_key;
   logic [DEPTH_BITS-1:0]    e_depth;
   logic signed [SCORE_W-1:0] e_score;
   logic [KIND_W-1:0]        e_kind;
   logic                     eval_hit;
   logic signed [SCORE_W-1:0] eval_score;

   logic                      rsp_hit_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         key_ff   <= req_position_key;
         depth_ff <= DEPTH_BITS'(req_search_depth);
         alpha_ff <= req_lower_bound;
         beta_ff  <= req_upper_bound;
         score_ff <= req_store_score;
         kind_ff  <= req_bound_kind;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         assign index      = key_ff[IDX_W-1:0];
         assign index_done = 1'b1;
      end else begin : g_reduce
         localparam int unsigned CNT_W = $clog2(KEY_W);
         localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(KEY_W - 1);
         localparam logic [IDX_W:0]   MODULUS   = (IDX_W + 1)'(TABLE_ENTRIES);

         logic [IDX_W-1:0] rem_ff, rem_in;
         logic [KEY_W-1:0] shift_ff, shift_in;
         logic [CNT_W-1:0] cnt_ff, cnt_in;
         logic [IDX_W:0]   trial;

         // Bit-serial remainder, most significant key bit first: double the
         // partial remainder, add the next bit, subtract the table size if it fits.
         always_comb begin
            trial    = {rem_ff, shift_ff[KEY_W-1]};
            rem_in   = rem_ff;
            shift_in = shift_ff;
            cnt_in   = cnt_ff;
            if (cmd.capture) begin
               rem_in   = '0;
               shift_in = req_position_key;
               cnt_in   = '0;
            end else if (cmd.index_step) begin
               rem_in   = (trial >= MODULUS) ? IDX_W'(trial - MODULUS) : trial[IDX_W-1:0];
               shift_in = {shift_ff[KEY_W-2:0], 1'b0};
               cnt_in   = cnt_ff + 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            rem_ff   <= rem_in;
            shift_ff <= shift_in;
            cnt_ff   <= cnt_in;
         end

         assign index      = rem_ff;
         assign index_done = (cnt_ff == LAST_STEP);
      end
   endgenerate

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   assign ram_addr    = cmd.sweep ? sweep_ff : index;
   assign ram_wr_en   = cmd.sweep || cmd.mem_write;
   assign ram_wr_data = cmd.sweep ? '0 : {1'b1, key_ff, score_ff, depth_ff, kind_ff};

   ttps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_wr_en),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // An empty slot reads as an all-zero exact entry.
   always_comb begin
      e_valid    = ram_rd_data[VALID_BIT];
      e_key      = e_valid ? ram_rd_data[KEY_LSB +: KEY_W] : '0;
      e_score    = e_valid ? ram_rd_data[SCORE_LSB +: SCORE_W] : '0;
      e_depth    = e_valid ? ram_rd_data[DEPTH_LSB +: DEPTH_BITS] : '0;
      e_kind     = e_valid ? ram_rd_data[0 +: KIND_W] : KIND_EXACT;
      eval_hit   = 1'b0;
      eval_score = '0;
      if (e_key == key_ff && e_depth == depth_ff) begin
         case (e_kind)
            KIND_EXACT: begin
               eval_hit   = 1'b1;
               eval_score = e_score;
            end
            KIND_ALPHA: begin
               if (e_score <= alpha_ff) begin
                  eval_hit   = 1'b1;
                  eval_score = alpha_ff;
               end
            end
            KIND_BETA: begin
               if (e_score >= beta_ff) begin
                  eval_hit   = 1'b1;
                  eval_score = beta_ff;
               end
            end
            default: begin
               eval_hit   = 1'b0;
               eval_score = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_eval) begin
         rsp_hit_ff   <= eval_hit;
         rsp_score_ff <= eval_score;
      end else if (cmd.load_zero) begin
         rsp_hit_ff   <= 1'b0;
         rsp_score_ff <= '0;
      end
   end

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_result_score = rsp_score_ff;

   assign status.op         = op_ff;
   assign status.index_done = index_done;
   assign status.sweep_last = (sweep_ff == SWEEP_LAST);

endmodule

// ===== rtl/core/transposition_table_probe_store_top.sv =====
// Direct-mapped transposition table. Each request is a probe, a store or a
// clear of the whole table, and each gives exactly one response (hit and
// score; hit 0 and score 0 for anything but a successful probe). The slot is
// position_key modulo TABLE_ENTRIES, held in one single-port table memory.
// One request is worked at a time: with a power-of-two TABLE_ENTRIES a probe
// or a store goes from acceptance to its response being loaded through index,
// memory access, evaluation or write, and response, and another request can
// be accepted the cycle after; any other table size adds a bit-serial slot
// reduction of the 64-bit key to the index step. A clear sweeps the memory
// one slot per cycle. After reset the same sweep runs with req_ready low. A
// finished response waits in an output register, so the next request is
// taken while the previous response has not yet been consumed.
module transposition_table_probe_store_top #(
   parameter int unsigned TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned DEPTH_BITS    = ttps_pkg::DEPTH_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic        [ttps_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic        [ttps_pkg::KEY_W-1:0]       req_position_key,
   input  logic        [ttps_pkg::REQ_DEPTH_W-1:0] req_search_depth,
   input  logic signed [ttps_pkg::SCORE_W-1:0]     req_lower_bound,
   input  logic signed [ttps_pkg::SCORE_W-1:0]     req_upper_bound,
   input  logic signed [ttps_pkg::SCORE_W-1:0]     req_store_score,
   input  logic        [ttps_pkg::KIND_W-1:0]      req_bound_kind,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_hit,
   output logic signed [ttps_pkg::SCORE_W-1:0]     rsp_result_score
);

   import ttps_pkg::*;

   cmd_type    cmd;
   status_type status;

   ttps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttps_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_position_key (req_position_key),
      .req_search_depth (req_search_depth),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_store_score  (req_store_score),
      .req_bound_kind   (req_bound_kind),
      .rsp_hit          (rsp_hit),
      .rsp_result_score (rsp_result_score)
   );

endmodule

// ===== bench/transposition_table_probe_store_top_test.sv =====
`timescale 1ns / 1ps

module transposition_table_probe_store_top_test;
   import ttps_pkg::*;

   localparam int unsigned TT_SLOTS       = TABLE_ENTRIES_DEF;
   localparam int unsigned KEY_POOL       = 16;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 50000;
   localparam int unsigned TAIL_CYCLES    = 20;

   // Codes outside the defined sets, used to exercise the ignore paths.
   localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
   localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0]       opcode;
      logic [KEY_W-1:0]          key;
      logic [REQ_DEPTH_W-1:0]    depth;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
      logic signed [SCORE_W-1:0] score;
      logic [KIND_W-1:0]         kind;
      bit                        typed;
      bit                        exp_hit;
      logic signed [SCORE_W-1:0] exp_score;
   } tt_request_t;

   typedef struct {
      bit                        hit;
      logic signed [SCORE_W-1:0] score;
   } tt_answer_t;

   typedef struct {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [REQ_DEPTH_W-1:0]    depth;
      logic [KIND_W-1:0]         kind;
   } tt_slot_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = OP_PROBE;
   logic [KEY_W-1:0]          req_position_key = '0;
   logic [REQ_DEPTH_W-1:0]    req_search_depth = '0;
   logic signed [SCORE_W-1:0] req_lower_bound = '0;
   logic signed [SCORE_W-1:0] req_upper_bound = '0;
   logic signed [SCORE_W-1:0] req_store_score = '0;
   logic [KIND_W-1:0]         req_bound_kind = KIND_EXACT;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic signed [SCORE_W-1:0] rsp_result_score;

   // Typed-in expectation travels with the request it belongs to.
   bit                        req_typed = 1'b0;
   bit                        req_exp_hit = 1'b0;
   logic signed [SCORE_W-1:0] req_exp_score = '0;

   tt_slot_t   slot_mem [TT_SLOTS];
   bit         slot_live [TT_SLOTS];
   tt_answer_t answer_q [$];

   logic [KEY_W-1:0] key_pool [KEY_POOL];
   logic [REQ_DEPTH_W-1:0] depth_note [KEY_POOL];
   int         score_note [KEY_POOL];

   int unsigned send_idle_pct = 38;
   int unsigned rsp_idle_pct = 54;
   int unsigned hold_left = 0;
   bit          hold_kick = 1'b0;
   bit          hold_seen = 1'b0;
   int unsigned quiet_cycles = 0;
   int          errors = 0;
   int          rsp_count = 0;

   tt_request_t directed_rows [25] = '{
      '{OP_PROBE, 64'h0, 7'd0, 18'sd0, 18'sd0, 18'sd0, KIND_EXACT, 1, 1, 18'sd0},
      '{OP_PROBE, 64'h0, 7'd1, 18'sd0, 18'sd0, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h1000, 7'd0, 18'sd0, 18'sd0, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 18'sd0, 18'sd0, 18'sd100000,
        KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 18'sd0, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 1, 18'sd100000},
      '{OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd126, 18'sd0, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 0, 18'sd0},
      '{OP_STORE, 64'h8000_0000_0000_0FFF, 7'd5, 18'sd0, 18'sd0, -18'sd100000,
        KIND_ALPHA, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h8000_0000_0000_0FFF, 7'd5, -18'sd100000, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 1, -18'sd100000},
      '{OP_PROBE, 64'h8000_0000_0000_0FFF, 7'd5, 18'sd100000, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 1, 18'sd100000},
      '{OP_PROBE, 64'h8000_0000_0000_0FFF, 7'd5, 18'sh20000, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 18'sd0, 18'sd0, 18'sd0,
        KIND_EXACT, 1, 0, 18'sd0},
      '{OP_STORE, 64'h123, 7'd10, 18'sd0, 18'sd0, 18'sd500, KIND_BETA, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h123, 7'd10, 18'sd0, 18'sd500, 18'sd0, KIND_EXACT, 1, 1, 18'sd500},
      '{OP_PROBE, 64'h123, 7'd10, 18'sd0, 18'sd501, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h123, 7'd10, 18'sd0, 18'sh20000, 18'sd0, KIND_EXACT, 1, 1,
        18'sh20000},
      '{OP_STORE, 64'h124, 7'd3, 18'sd0, 18'sd0, 18'sd7, KIND_UNUSED, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h124, 7'd3, 18'sd100000, -18'sd100000, 18'sd0, KIND_EXACT, 1, 0,
        18'sd0},
      '{OP_UNUSED, 64'h123, 7'd10, 18'sd0, 18'sd0, 18'sd9, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h123, 7'd10, 18'sd0, 18'sd500, 18'sd0, KIND_EXACT, 1, 1, 18'sd500},
      '{OP_STORE, 64'h555, 7'd0, 18'sd0, 18'sd0, -18'sd1, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_CLEAR, 64'h0, 7'd0, 18'sd0, 18'sd0, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h555, 7'd0, 18'sd0, 18'sd0, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h123, 7'd10, 18'sd0, 18'sd500, 18'sd0, KIND_EXACT, 1, 0, 18'sd0},
      '{OP_STORE, 64'h0, 7'd0, 18'sd0, 18'sd0, 18'sh1FFFF, KIND_ALPHA, 1, 0, 18'sd0},
      '{OP_PROBE, 64'h0, 7'd0, 18'sh1FFFE, 18'sd0, 18'sd0, KIND_EXACT, 0, 0, 18'sd0}
   };

   transposition_table_probe_store_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_position_key (req_position_key),
      .req_search_depth (req_search_depth),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_store_score  (req_store_score),
      .req_bound_kind   (req_bound_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_result_score (rsp_result_score)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one request to the table image and returns the response it earns.
   function automatic tt_answer_t probe_or_update(input tt_request_t r);
      tt_answer_t  a;
      tt_slot_t    s;
      int unsigned idx;
      a.hit = 1'b0;
      a.score = '0;
      idx = int'(r.key % TT_SLOTS);
      case (r.opcode)
         OP_PROBE: begin
            // An empty slot reads as an all-zero exact entry.
            s.key = '0;
            s.score = '0;
            s.depth = '0;
            s.kind = KIND_EXACT;
            if (slot_live[idx]) s = slot_mem[idx];
            if (s.key == r.key && s.depth == r.depth) begin
               if (s.kind == KIND_EXACT) begin
                  a.hit = 1'b1;
                  a.score = s.score;
               end else if (s.kind == KIND_ALPHA && s.score <= r.alpha) begin
                  a.hit = 1'b1;
                  a.score = r.alpha;
               end else if (s.kind == KIND_BETA && s.score >= r.beta) begin
                  a.hit = 1'b1;
                  a.score = r.beta;
               end
            end
         end
         OP_STORE: begin
            slot_mem[idx].key = r.key;
            slot_mem[idx].score = r.score;
            slot_mem[idx].depth = r.depth;
            slot_mem[idx].kind = r.kind;
            slot_live[idx] = 1'b1;
         end
         OP_CLEAR: begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   // Mostly store/probe pairs over a small key pool so probes find their
   // entries; the rest is fully random noise and the odd clear.
   function automatic tt_request_t random_request();
      tt_request_t r;
      int unsigned pick;
      int unsigned n;
      int          sn;
      r.typed = 1'b0;
      r.exp_hit = 1'b0;
      r.exp_score = '0;
      r.opcode = $urandom_range(0, 3);
      r.key = {$urandom, $urandom};
      r.depth = $urandom;
      r.alpha = $urandom;
      r.beta = $urandom;
      r.score = $urandom;
      r.kind = $urandom;
      pick = $urandom_range(0, 99);
      n = $urandom_range(0, KEY_POOL - 1);
      if (pick < 1) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 10) begin
         if (r.opcode == OP_CLEAR) r.opcode = OP_PROBE;
      end else if (pick < 50) begin
         r.opcode = OP_STORE;
         r.key = key_pool[n];
         if ($urandom_range(0, 3) != 0) r.depth = $urandom_range(0, 12);
         sn = int'($urandom_range(0, 200000)) - 100000;
         r.score = SCORE_W'(sn);
         if ($urandom_range(0, 15) == 0) begin
            r.kind = KIND_UNUSED;
         end else begin
            r.kind = $urandom_range(0, 2);
         end
         depth_note[n] = r.depth;
         score_note[n] = sn;
      end else begin
         r.opcode = OP_PROBE;
         r.key = key_pool[n];
         if ($urandom_range(0, 3) != 0) r.depth = depth_note[n];
         sn = score_note[n] + int'($urandom_range(0, 16)) - 8;
         r.alpha = SCORE_W'(sn);
         sn = score_note[n] + int'($urandom_range(0, 16)) - 8;
         r.beta = SCORE_W'(sn);
      end
      return r;
   endfunction

   task automatic offer_request(input tt_request_t r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_position_key <= r.key;
      req_search_depth <= r.depth;
      req_lower_bound <= r.alpha;
      req_upper_bound <= r.beta;
      req_store_score <= r.score;
      req_bound_kind <= r.kind;
      req_typed <= r.typed;
      req_exp_hit <= r.exp_hit;
      req_exp_score <= r.exp_score;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_burst(input int unsigned count);
      repeat (count) offer_request(random_request());
   endtask

   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : request_capture
      tt_request_t seen;
      tt_answer_t  a;
      if (!reset && req_valid && req_ready) begin
         seen.opcode = req_opcode;
         seen.key = req_position_key;
         seen.depth = req_search_depth;
         seen.alpha = req_lower_bound;
         seen.beta = req_upper_bound;
         seen.score = req_store_score;
         seen.kind = req_bound_kind;
         a = probe_or_update(seen);
         if (req_typed) begin
            a.hit = req_exp_hit;
            a.score = req_exp_score;
         end
         answer_q.push_back(a);
      end
   end

   always @(posedge clock) begin : response_check
      tt_answer_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (answer_q.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10)
               $display("response %0d arrived with no request outstanding", rsp_count);
         end else begin
            want = answer_q.pop_front();
            if (rsp_hit !== want.hit || rsp_result_score !== want.score) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("response %0d: expected hit %0b score %0d, got hit %0b score %0d",
                           rsp_count, want.hit, want.score, rsp_hit, rsp_result_score);
            end
         end
      end
   end

   // Nothing accepted on either side for too long means the block has hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("transposition_table_probe_store_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      foreach (key_pool[i]) begin
         key_pool[i] = {$urandom, $urandom};
         // Pairs of keys share a slot so that stores evict each other (key 0, set below, leaves its pair).
         if (i % 2 == 1) key_pool[i][11:0] = key_pool[i-1][11:0];
         depth_note[i] = '0;
         score_note[i] = 0;
      end
      key_pool[0] = '0;

      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      rsp_idle_pct = 54;
      foreach (directed_rows[i]) offer_request(directed_rows[i]);
      random_burst(170);

      send_idle_pct = 54;
      rsp_idle_pct = 38;
      random_burst(170);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      // The sender keeps offering while responses are held back, so the
      // output register fills and the block has to stall its input.
      hold_kick <= ~hold_kick;
      random_burst(160);
      req_valid <= 1'b0;

      while (answer_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("transposition_table_probe_store_top: match");
      end else begin
         $display("transposition_table_probe_store_top: mismatch");
      end
      $finish;
   end

endmodule
